// ----- design/conv2d_multichannel_stride_pad_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the convolution unit.
// Concurrent assertion shorthands clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONV2D_MULTICHANNEL_STRIDE_PAD_UNIT_MACROS_SVH
`define CONV2D_MULTICHANNEL_STRIDE_PAD_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define C2DMSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define C2DMSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/c2dmsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Convolution unit package
// Shared constants, operation codes and control types of the convolution unit.
// ----------------------------------------------------------------------------
package c2dmsp_pkg;

   localparam int MAX_MAP_DEFAULT      = 32;
   localparam int MAX_FILTER_DEFAULT   = 7;
   localparam int MAX_CHANNELS_DEFAULT = 8;

   localparam int VALUE_W = 16;
   localparam int PROD_W  = 32;
   localparam int BIAS_W  = 32;
   localparam int SUM_W   = 48;
   localparam int COORD_W = 6;
   localparam int CHAN_W  = 3;
   // Signed tap coordinate and unsigned bound arithmetic widths.
   localparam int POS_W   = 10;
   localparam int EXT_W   = 11;

   localparam logic [1:0] OP_LOAD_INPUT  = 2'd0;
   localparam logic [1:0] OP_LOAD_WEIGHT = 2'd1;
   localparam logic [1:0] OP_COMPUTE     = 2'd2;

   localparam logic [2:0] REG_MAP_SIZE      = 3'd0;
   localparam logic [2:0] REG_FILTER_SIZE   = 3'd1;
   localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
   localparam logic [2:0] REG_STEP_STRIDE   = 3'd3;
   localparam logic [2:0] REG_ZERO_PAD      = 3'd4;
   localparam logic [2:0] REG_BIAS_VALUE    = 3'd5;

   localparam logic [5:0]  MAP_SIZE_RESET      = 6'd32;
   localparam logic [2:0]  FILTER_SIZE_RESET   = 3'd3;
   localparam logic [3:0]  CHANNEL_COUNT_RESET = 4'd1;
   localparam logic [2:0]  STEP_STRIDE_RESET   = 3'd1;
   localparam logic [1:0]  ZERO_PAD_RESET      = 2'd0;
   localparam logic [31:0] BIAS_VALUE_RESET    = 32'd0;

   typedef struct packed {
      logic valid;
      logic inrange;
      logic last;
   } tap_ctrl_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic int count_width(input int max_value);
      return $clog2(max_value + 1);
   endfunction

endpackage

// ----- design/c2dmsp_mac.sv -----
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Multiplies one input and weight pair per cycle and adds the product to a
// 48-bit accumulator that starts from the bias.
// ----------------------------------------------------------------------------
module c2dmsp_mac
   import c2dmsp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic signed [BIAS_W-1:0] bias,
   input  tap_ctrl_type             tap,
   input  logic signed [VALUE_W-1:0] rd_input,
   input  logic signed [VALUE_W-1:0] rd_weight,
   output logic signed [SUM_W-1:0]  acc,
   output logic                     done
);

   tap_ctrl_type               tap_d1_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       pvalid_ff;
   logic                       plast_ff;
   logic signed [SUM_W-1:0]    acc_ff;
   logic                       done_ff;

   always_comb begin
      prod_in = '0;
      if (tap_d1_ff.inrange) begin
         prod_in = rd_input * rd_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_d1_ff <= '0;
         pvalid_ff <= 1'b0;
         plast_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         tap_d1_ff <= tap;
         pvalid_ff <= tap_d1_ff.valid;
         plast_ff  <= tap_d1_ff.valid && tap_d1_ff.last;
         done_ff   <= pvalid_ff && plast_ff && !clear;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (clear) begin
         acc_ff <= {{(SUM_W - BIAS_W){bias[BIAS_W-1]}}, bias};
      end else if (pvalid_ff) begin
         acc_ff <= acc_ff + {{(SUM_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

// ----- design/c2dmsp_seq.sv -----
// ----------------------------------------------------------------------------
// Tap sequencer
// Walks filter rows, filter columns and channels one tap per cycle, forms the
// store addresses and the border test, and hands the result to the output.
// ----------------------------------------------------------------------------
module c2dmsp_seq
   import c2dmsp_pkg::*;
#(
   parameter int MAX_MAP      = MAX_MAP_DEFAULT,
   parameter int MAX_FILTER   = MAX_FILTER_DEFAULT,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT,
   localparam int MW  = count_width(MAX_MAP),
   localparam int FW  = count_width(MAX_FILTER),
   localparam int CW  = count_width(MAX_CHANNELS),
   localparam int IAW = addr_width(MAX_CHANNELS * MAX_MAP * MAX_MAP),
   localparam int WAW = addr_width(MAX_CHANNELS * MAX_FILTER * MAX_FILTER)
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    skip,
   input  logic [MW-1:0]           map_eff,
   input  logic [FW-1:0]           filt_eff,
   input  logic [CW-1:0]           chan_eff,
   input  logic signed [POS_W-1:0] y0,
   input  logic signed [POS_W-1:0] x0,
   input  logic                    mac_done,
   input  logic                    out_free,
   output logic                    ready,
   output tap_ctrl_type            tap,
   output logic [IAW-1:0]          in_addr,
   output logic [WAW-1:0]          w_addr,
   output logic                    out_load
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [FW-1:0]           ty_ff, ty_in;
   logic [FW-1:0]           tx_ff, tx_in;
   logic [CW-1:0]           d_ff, d_in;
   logic signed [POS_W-1:0] y0_ff, x0_ff;
   logic signed [POS_W-1:0] iy, ix;
   logic                    last_tap;
   logic                    inrange;
   logic [31:0]             in_lin;
   logic [31:0]             w_lin;

   assign iy = y0_ff + $signed(POS_W'(ty_ff));
   assign ix = x0_ff + $signed(POS_W'(tx_ff));

   assign inrange = (iy >= 0) && (ix >= 0) &&
                    (iy < $signed(POS_W'(map_eff))) && (ix < $signed(POS_W'(map_eff)));

   assign last_tap = (ty_ff == FW'(filt_eff - 1'b1)) && (tx_ff == FW'(filt_eff - 1'b1)) &&
                     (d_ff == CW'(chan_eff - 1'b1));

   assign in_lin = ((32'(d_ff) * MAX_MAP) + 32'(iy[POS_W-1:0])) * MAX_MAP
                   + 32'(ix[POS_W-1:0]);
   assign w_lin  = ((32'(d_ff) * MAX_FILTER) + 32'(ty_ff)) * MAX_FILTER + 32'(tx_ff);

   assign in_addr = in_lin[IAW-1:0];
   assign w_addr  = w_lin[WAW-1:0];

   always_comb begin
      state_in = state_ff;
      ty_in    = ty_ff;
      tx_in    = tx_ff;
      d_in     = d_ff;
      tap      = '0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ty_in    = '0;
               tx_in    = '0;
               d_in     = '0;
               state_in = skip ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            tap.valid   = 1'b1;
            tap.inrange = inrange;
            tap.last    = last_tap;
            if (last_tap) begin
               state_in = ST_DRAIN;
            end else if (d_ff == CW'(chan_eff - 1'b1)) begin
               d_in = '0;
               if (tx_ff == FW'(filt_eff - 1'b1)) begin
                  tx_in = '0;
                  ty_in = ty_ff + 1'b1;
               end else begin
                  tx_in = tx_ff + 1'b1;
               end
            end else begin
               d_in = d_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ty_ff <= ty_in;
      tx_ff <= tx_in;
      d_ff  <= d_in;
      if (start && (state_ff == ST_IDLE)) begin
         y0_ff <= y0;
         x0_ff <= x0;
      end
   end

   assign ready = (state_ff == ST_IDLE);

endmodule

// ----- design/conv2d_multichannel_stride_pad_unit.sv -----
// ----------------------------------------------------------------------------
// Multichannel 2-D convolution unit with stride and zero padding
//
// The request stream carries one transaction per item: req_tuser holds the
// opcode. A load input or load weight transaction writes one element of the
// input map or the filter and leaves req_tready high; loads outside the
// configured sizes are dropped. A compute transaction names one output
// position and returns one response transaction with the sum and an error
// flag. A compute runs filter_size * filter_size * channel_count taps on the
// single multiply-accumulate unit, one tap per cycle. Its response becomes
// valid when req_tready rises again. A position outside the output map, or a
// channel count of zero, gives its response without running any taps.
// req_tready is low while a compute is in progress.
// The response sits in an output register. While the receiver stalls, the
// unit still accepts loads and finishes at most one further compute, which
// then waits for the register to drain.
// Registers are written through the csr channel, which is always ready; the
// user must write them only while the unit is idle, which the unit itself
// does not enforce. Reset restores the register defaults and empties
// the pipeline; the stores keep their contents and must be loaded before use.
// ----------------------------------------------------------------------------
module conv2d_multichannel_stride_pad_unit
   import c2dmsp_pkg::*;
#(
   parameter int MAX_MAP      = MAX_MAP_DEFAULT,
   parameter int MAX_FILTER   = MAX_FILTER_DEFAULT,
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // channel, row, col, value, zero fill
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_row, out_col, sum, zero fill
   output logic [0:0]  rsp_tuser,   // position_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int MW        = count_width(MAX_MAP);
   localparam int FW        = count_width(MAX_FILTER);
   localparam int CW        = count_width(MAX_CHANNELS);
   localparam int IN_DEPTH  = MAX_CHANNELS * MAX_MAP * MAX_MAP;
   localparam int W_DEPTH   = MAX_CHANNELS * MAX_FILTER * MAX_FILTER;
   localparam int IAW       = addr_width(IN_DEPTH);
   localparam int WAW       = addr_width(W_DEPTH);

   logic [5:0]               map_size_ff;
   logic [2:0]               filter_size_ff;
   logic [3:0]               channel_count_ff;
   logic [2:0]               step_stride_ff;
   logic [1:0]               zero_pad_ff;
   logic [BIAS_W-1:0]        bias_value_ff;

   logic [MW-1:0]            map_eff;
   logic [FW-1:0]            filt_eff;
   logic [CW-1:0]            chan_eff;
   logic [2:0]               stride_eff;

   logic [1:0]               req_opcode;
   logic [CHAN_W-1:0]        req_channel;
   logic [COORD_W-1:0]       req_row;
   logic [COORD_W-1:0]       req_col;
   logic [VALUE_W-1:0]       req_value;
   logic                     req_accept;

   logic [EXT_W-1:0]         row_scaled;
   logic [EXT_W-1:0]         col_scaled;
   logic [EXT_W-1:0]         span;
   logic [EXT_W-1:0]         filt_ext;
   logic                     pos_err;
   logic signed [POS_W-1:0]  y0;
   logic signed [POS_W-1:0]  x0;
   logic                     start;
   logic                     skip;

   logic                     in_we;
   logic                     w_we;
   logic [31:0]              in_wlin;
   logic [31:0]              w_wlin;
   logic [VALUE_W-1:0]       input_store_ff [IN_DEPTH];
   logic [VALUE_W-1:0]       weight_store_ff [W_DEPTH];
   logic [VALUE_W-1:0]       in_rdata_ff;
   logic [VALUE_W-1:0]       w_rdata_ff;

   logic                     seq_ready;
   tap_ctrl_type             tap;
   logic [IAW-1:0]           in_raddr;
   logic [WAW-1:0]           w_raddr;
   logic                     out_load;
   logic                     out_free;
   logic signed [SUM_W-1:0]  acc;
   logic                     mac_done;

   logic [COORD_W-1:0]       pend_row_ff;
   logic [COORD_W-1:0]       pend_col_ff;
   logic                     pend_err_ff;

   logic                     rsp_tvalid_ff;
   logic [COORD_W-1:0]       rsp_row_ff;
   logic [COORD_W-1:0]       rsp_col_ff;
   logic [SUM_W-1:0]         rsp_sum_ff;
   logic                     rsp_err_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff      <= MAP_SIZE_RESET;
         filter_size_ff   <= FILTER_SIZE_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
         step_stride_ff   <= STEP_STRIDE_RESET;
         zero_pad_ff      <= ZERO_PAD_RESET;
         bias_value_ff    <= BIAS_VALUE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MAP_SIZE:      map_size_ff      <= csr_data[5:0];
            REG_FILTER_SIZE:   filter_size_ff   <= csr_data[2:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_data[3:0];
            REG_STEP_STRIDE:   step_stride_ff   <= csr_data[2:0];
            REG_ZERO_PAD:      zero_pad_ff      <= csr_data[1:0];
            REG_BIAS_VALUE:    bias_value_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      priority if (map_size_ff == '0) begin
         map_eff = MW'(1);
      end else if (int'(map_size_ff) > MAX_MAP) begin
         map_eff = MW'(MAX_MAP);
      end else begin
         map_eff = MW'(map_size_ff);
      end
      priority if (filter_size_ff == '0) begin
         filt_eff = FW'(1);
      end else if (int'(filter_size_ff) > MAX_FILTER) begin
         filt_eff = FW'(MAX_FILTER);
      end else begin
         filt_eff = FW'(filter_size_ff);
      end
      if (int'(channel_count_ff) > MAX_CHANNELS) begin
         chan_eff = CW'(MAX_CHANNELS);
      end else begin
         chan_eff = CW'(channel_count_ff);
      end
      stride_eff = (step_stride_ff == '0) ? 3'd1 : step_stride_ff;
   end

   assign req_opcode  = req_tuser;
   assign req_channel = req_tdata[2:0];
   assign req_row     = req_tdata[8:3];
   assign req_col     = req_tdata[14:9];
   assign req_value   = req_tdata[30:15];
   assign req_accept  = req_tvalid && req_tready;

   // A position is inside the output map when pos * stride + filter <= padded size.
   assign row_scaled = EXT_W'(req_row) * EXT_W'(stride_eff);
   assign col_scaled = EXT_W'(req_col) * EXT_W'(stride_eff);
   assign span       = EXT_W'(map_eff) + EXT_W'({zero_pad_ff, 1'b0});
   assign filt_ext   = EXT_W'(filt_eff);
   assign pos_err    = ((row_scaled + filt_ext) > span) || ((col_scaled + filt_ext) > span);
   assign y0         = $signed(POS_W'(row_scaled)) - $signed(POS_W'(zero_pad_ff));
   assign x0         = $signed(POS_W'(col_scaled)) - $signed(POS_W'(zero_pad_ff));

   assign start = req_accept && (req_opcode == OP_COMPUTE);
   assign skip  = pos_err || (chan_eff == '0);

   always_ff @(posedge clock) begin
      if (start) begin
         pend_row_ff <= req_row;
         pend_col_ff <= req_col;
         pend_err_ff <= pos_err;
      end
   end

   // Element stores.
   assign in_we = req_accept && (req_opcode == OP_LOAD_INPUT) && (req_channel < chan_eff) &&
                  (req_row < map_eff) && (req_col < map_eff);
   assign w_we  = req_accept && (req_opcode == OP_LOAD_WEIGHT) && (req_channel < chan_eff) &&
                  (req_row < filt_eff) && (req_col < filt_eff);

   assign in_wlin = ((32'(req_channel) * MAX_MAP) + 32'(req_row)) * MAX_MAP + 32'(req_col);
   assign w_wlin  = ((32'(req_channel) * MAX_FILTER) + 32'(req_row)) * MAX_FILTER
                    + 32'(req_col);

   always_ff @(posedge clock) begin
      if (in_we) begin
         input_store_ff[in_wlin[IAW-1:0]] <= req_value;
      end
      in_rdata_ff <= input_store_ff[in_raddr];
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_store_ff[w_wlin[WAW-1:0]] <= req_value;
      end
      w_rdata_ff <= weight_store_ff[w_raddr];
   end

   c2dmsp_seq #(
      .MAX_MAP      (MAX_MAP),
      .MAX_FILTER   (MAX_FILTER),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .skip     (skip),
      .map_eff  (map_eff),
      .filt_eff (filt_eff),
      .chan_eff (chan_eff),
      .y0       (y0),
      .x0       (x0),
      .mac_done (mac_done),
      .out_free (out_free),
      .ready    (seq_ready),
      .tap      (tap),
      .in_addr  (in_raddr),
      .w_addr   (w_raddr),
      .out_load (out_load)
   );

   c2dmsp_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .clear     (start),
      .bias      ($signed(bias_value_ff)),
      .tap       (tap),
      .rd_input  ($signed(in_rdata_ff)),
      .rd_weight ($signed(w_rdata_ff)),
      .acc       (acc),
      .done      (mac_done)
   );

   assign req_tready = seq_ready;

   // Output register.
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_row_ff <= pend_row_ff;
         rsp_col_ff <= pend_col_ff;
         rsp_err_ff <= pend_err_ff;
         rsp_sum_ff <= pend_err_ff ? '0 : acc;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0000, rsp_sum_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ----- design/c2dmsp_chk.sv -----
// ----------------------------------------------------------------------------
// Convolution unit port checker
// Watches the top-level ports for sequencing and result rules, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "conv2d_multichannel_stride_pad_unit_macros.svh"

module c2dmsp_chk
   import c2dmsp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   `C2DMSP_ASSERT_NEXT(a_compute_blocks_requests,
      req_tvalid && req_tready && (req_tuser == OP_COMPUTE), !req_tready,
      "request channel ready right after a compute transaction")

   `C2DMSP_ASSERT_NEXT(a_load_gives_no_result,
      !rsp_tvalid && req_tvalid && req_tready && (req_tuser != OP_COMPUTE), !rsp_tvalid,
      "response appeared after a load transaction")

   `C2DMSP_ASSERT(a_error_sum_zero,
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[59:12] == '0),
      "position error response carries a nonzero sum")

   `C2DMSP_ASSERT_NEXT(a_rsp_holds,
      rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "stalled response transaction changed")

endmodule

bind conv2d_multichannel_stride_pad_unit c2dmsp_chk u_c2dmsp_chk (.*);
